// ===== design/tlbts_pkg.sv =====
`timescale 1ns / 1ps

package tlbts_pkg;

    localparam int TLBTS_SERIES_TERMS = 8;

    localparam int DATA_W    = 32;
    localparam int NUM_ELEMS = 9;
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W     = 40;
    localparam int DIV_BITS  = 8;
    localparam int DIV_CYCLES = ACC_W / DIV_BITS;
    localparam int DCNT_W    = $clog2(DIV_CYCLES);
    localparam int UC_LEN    = 45;
    localparam int PC_W      = 6;

    localparam logic signed [DATA_W-1:0] HALF_Q30 = 32'sh2000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY,
        CFG_RELAX,
        CFG_DEPHASE,
        CFG_DRIVE1,
        CFG_DRIVE2_RE,
        CFG_DRIVE2_IM,
        CFG_DETUNE1,
        CFG_DETUNE2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        EL_POP_UP,
        EL_POP_1,
        EL_POP_2,
        EL_C01_RE,
        EL_C01_IM,
        EL_C02_RE,
        EL_C02_IM,
        EL_C12_RE,
        EL_C12_IM
    } t_elem;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DRAIN,
        S_DIVST,
        S_DIV,
        S_WR,
        S_COPY,
        S_FIN
    } t_state;

    // one product of the bloch right-hand side
    typedef struct packed {
        t_cfg_idx coef;
        t_elem    src;
        logic     half;
        logic     neg;
        logic     dbl;
        logic     last;
    } t_uop;

    typedef struct packed {
        logic            load;
        logic            issue;
        logic [PC_W-1:0] pc;
        logic            div_start;
        logic            div_step;
        logic            write;
        t_elem           elem;
        logic            copy;
        logic            commit;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]        step_index;
        logic signed [DATA_W-1:0] pop_upper;
        logic signed [DATA_W-1:0] pop_first;
        logic signed [DATA_W-1:0] pop_second;
        logic signed [DATA_W-1:0] coh_up_first_re;
        logic signed [DATA_W-1:0] coh_up_first_im;
        logic signed [DATA_W-1:0] coh_up_second_re;
        logic signed [DATA_W-1:0] coh_up_second_im;
        logic signed [DATA_W-1:0] coh_lower_re;
        logic signed [DATA_W-1:0] coh_lower_im;
    } t_result;

    function automatic t_uop mk_uop(input t_cfg_idx c, input t_elem s, input logic h,
                                    input logic n, input logic d, input logic l);
        t_uop u;
        u.coef = c;
        u.src  = s;
        u.half = h;
        u.neg  = n;
        u.dbl  = d;
        u.last = l;
        return u;
    endfunction

    // product list, element by element; last marks the end of one derivative
    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk_uop(CFG_DECAY,     EL_POP_UP, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd1:  u = mk_uop(CFG_DRIVE1,    EL_C01_RE, 1'b0, 1'b1, 1'b1, 1'b0);
            6'd2:  u = mk_uop(CFG_DRIVE2_RE, EL_C02_RE, 1'b0, 1'b1, 1'b1, 1'b0);
            6'd3:  u = mk_uop(CFG_DRIVE2_IM, EL_C02_IM, 1'b0, 1'b1, 1'b1, 1'b1);
            6'd4:  u = mk_uop(CFG_DECAY,     EL_POP_UP, 1'b1, 1'b0, 1'b0, 1'b0);
            6'd5:  u = mk_uop(CFG_RELAX,     EL_POP_1,  1'b1, 1'b1, 1'b0, 1'b0);
            6'd6:  u = mk_uop(CFG_RELAX,     EL_POP_2,  1'b1, 1'b0, 1'b0, 1'b0);
            6'd7:  u = mk_uop(CFG_DRIVE1,    EL_C01_RE, 1'b0, 1'b0, 1'b1, 1'b1);
            6'd8:  u = mk_uop(CFG_DECAY,     EL_POP_UP, 1'b1, 1'b0, 1'b0, 1'b0);
            6'd9:  u = mk_uop(CFG_RELAX,     EL_POP_2,  1'b1, 1'b1, 1'b0, 1'b0);
            6'd10: u = mk_uop(CFG_RELAX,     EL_POP_1,  1'b1, 1'b0, 1'b0, 1'b0);
            6'd11: u = mk_uop(CFG_DRIVE2_RE, EL_C02_RE, 1'b0, 1'b0, 1'b1, 1'b0);
            6'd12: u = mk_uop(CFG_DRIVE2_IM, EL_C02_IM, 1'b0, 1'b0, 1'b1, 1'b1);
            6'd13: u = mk_uop(CFG_DECAY,     EL_C01_RE, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd14: u = mk_uop(CFG_DETUNE2,   EL_C01_IM, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd15: u = mk_uop(CFG_DRIVE1,    EL_POP_UP, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd16: u = mk_uop(CFG_DRIVE1,    EL_POP_1,  1'b0, 1'b1, 1'b0, 1'b0);
            6'd17: u = mk_uop(CFG_DRIVE2_RE, EL_C12_IM, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd18: u = mk_uop(CFG_DRIVE2_IM, EL_C12_RE, 1'b0, 1'b0, 1'b0, 1'b1);
            6'd19: u = mk_uop(CFG_DECAY,     EL_C01_IM, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd20: u = mk_uop(CFG_DETUNE2,   EL_C01_RE, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd21: u = mk_uop(CFG_DRIVE2_RE, EL_C12_RE, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd22: u = mk_uop(CFG_DRIVE2_IM, EL_C12_IM, 1'b0, 1'b1, 1'b0, 1'b1);
            6'd23: u = mk_uop(CFG_DECAY,     EL_C02_RE, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd24: u = mk_uop(CFG_DETUNE1,   EL_C02_IM, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd25: u = mk_uop(CFG_DRIVE2_RE, EL_POP_UP, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd26: u = mk_uop(CFG_DRIVE2_RE, EL_POP_2,  1'b0, 1'b1, 1'b0, 1'b0);
            6'd27: u = mk_uop(CFG_DRIVE1,    EL_C12_IM, 1'b0, 1'b1, 1'b0, 1'b1);
            6'd28: u = mk_uop(CFG_DECAY,     EL_C02_IM, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd29: u = mk_uop(CFG_DETUNE1,   EL_C02_RE, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd30: u = mk_uop(CFG_DRIVE2_IM, EL_POP_UP, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd31: u = mk_uop(CFG_DRIVE2_IM, EL_POP_2,  1'b0, 1'b1, 1'b0, 1'b0);
            6'd32: u = mk_uop(CFG_DRIVE1,    EL_C12_RE, 1'b0, 1'b0, 1'b0, 1'b1);
            6'd33: u = mk_uop(CFG_DEPHASE,   EL_C12_RE, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd34: u = mk_uop(CFG_DETUNE2,   EL_C12_IM, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd35: u = mk_uop(CFG_DETUNE1,   EL_C12_IM, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd36: u = mk_uop(CFG_DRIVE2_RE, EL_C01_IM, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd37: u = mk_uop(CFG_DRIVE1,    EL_C02_IM, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd38: u = mk_uop(CFG_DRIVE2_IM, EL_C01_RE, 1'b0, 1'b1, 1'b0, 1'b1);
            6'd39: u = mk_uop(CFG_DEPHASE,   EL_C12_IM, 1'b1, 1'b1, 1'b0, 1'b0);
            6'd40: u = mk_uop(CFG_DETUNE2,   EL_C12_RE, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd41: u = mk_uop(CFG_DETUNE1,   EL_C12_RE, 1'b0, 1'b1, 1'b0, 1'b0);
            6'd42: u = mk_uop(CFG_DRIVE2_RE, EL_C01_RE, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd43: u = mk_uop(CFG_DRIVE1,    EL_C02_RE, 1'b0, 1'b0, 1'b0, 1'b0);
            6'd44: u = mk_uop(CFG_DRIVE2_IM, EL_C01_IM, 1'b0, 1'b0, 1'b0, 1'b1);
            default: u = mk_uop(CFG_DECAY,   EL_POP_UP, 1'b0, 1'b0, 1'b0, 1'b1);
        endcase
        return u;
    endfunction

    // clamp to the 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[ACC_W:DATA_W-1]) || !(|v[ACC_W:DATA_W-1])) begin
            r = v[DATA_W-1:0];
        end else if (v[ACC_W]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] init_val(input int unsigned i);
        logic signed [DATA_W-1:0] r;
        if (i == int'(EL_POP_1) || i == int'(EL_POP_2)) begin
            r = HALF_Q30;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// ===== design/tlbts_if.sv =====
`timescale 1ns / 1ps

interface tlbts_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface tlbts_out_if;
    logic               valid;
    logic               ready;
    logic [31:0]        step_index;
    logic signed [31:0] pop_upper;
    logic signed [31:0] pop_first;
    logic signed [31:0] pop_second;
    logic signed [31:0] coh_up_first_re;
    logic signed [31:0] coh_up_first_im;
    logic signed [31:0] coh_up_second_re;
    logic signed [31:0] coh_up_second_im;
    logic signed [31:0] coh_lower_re;
    logic signed [31:0] coh_lower_im;

    modport source (
        output valid, output step_index, output pop_upper, output pop_first,
        output pop_second, output coh_up_first_re, output coh_up_first_im,
        output coh_up_second_re, output coh_up_second_im, output coh_lower_re,
        output coh_lower_im, input ready
    );
    modport sink (
        input valid, input step_index, input pop_upper, input pop_first,
        input pop_second, input coh_up_first_re, input coh_up_first_im,
        input coh_up_second_re, input coh_up_second_im, input coh_lower_re,
        input coh_lower_im, output ready
    );
endinterface

// ===== design/tlbts_ctrl.sv =====
`timescale 1ns / 1ps

module tlbts_ctrl #(
    parameter int SERIES_TERMS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tlbts_pkg::t_cmd             o_cmd,
    output logic [$clog2(SERIES_TERMS)-1:0] o_k
);
    import tlbts_pkg::*;

    localparam int KW = $clog2(SERIES_TERMS);

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_elem           r_elem, n_elem;
    logic [KW-1:0]   r_k, n_k;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic            r_out_valid, n_out_valid;
    t_uop            w_uop;

    assign w_uop       = uop_at(r_pc);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_k         = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_elem      <= EL_POP_UP;
            r_k         <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_elem      <= n_elem;
            r_k         <= n_k;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_elem      = r_elem;
        n_k         = r_k;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.pc    = r_pc;
        o_cmd.elem  = r_elem;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pc       = '0;
                    n_elem     = EL_POP_UP;
                    n_k        = KW'(1);
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.issue = 1'b1;
                n_pc        = r_pc + 1'b1;
                if (w_uop.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DIVST;
            end
            S_DIVST: begin
                o_cmd.div_start = 1'b1;
                n_dcnt          = '0;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_dcnt         = r_dcnt + 1'b1;
                if (r_dcnt == DCNT_W'(DIV_CYCLES - 1)) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                o_cmd.write = 1'b1;
                if (r_elem == EL_C12_IM) begin
                    n_state = S_COPY;
                end else begin
                    n_elem  = t_elem'(r_elem + 4'd1);
                    n_state = S_MUL;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                n_pc       = '0;
                n_elem     = EL_POP_UP;
                if (r_k == KW'(SERIES_TERMS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/tlbts_dp.sv =====
`timescale 1ns / 1ps

module tlbts_dp #(
    parameter int SERIES_TERMS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tlbts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlbts_pkg::DATA_W-1:0]         i_cfg_wdata,
    input  logic                                 i_restart,
    input  tlbts_pkg::t_cmd                      i_cmd,
    input  logic [$clog2(SERIES_TERMS)-1:0]      i_k,
    output tlbts_pkg::t_result                   o_result
);
    import tlbts_pkg::*;

    localparam int KW = $clog2(SERIES_TERMS);
    localparam logic signed [63:0] RND_M = 64'sh0000_0000_0800_0000;
    localparam logic signed [63:0] RND_H = 64'sh0000_0000_1000_0000;

    logic signed [DATA_W-1:0] r_cfg     [NUM_CFG];
    logic signed [DATA_W-1:0] r_density [NUM_ELEMS];
    logic signed [DATA_W-1:0] r_term    [NUM_ELEMS];
    logic signed [DATA_W-1:0] r_nterm   [NUM_ELEMS];
    logic signed [DATA_W-1:0] r_sum     [NUM_ELEMS];
    logic [DATA_W-1:0]        r_step;

    logic signed [63:0]       r_prod;
    logic                     r_pvalid, r_phalf, r_pneg, r_pdbl;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]         r_dq;
    logic [KW-1:0]            r_rem;
    logic                     r_dsign;
    t_result                  r_out;

    t_uop                     w_uop;
    logic signed [63:0]       w_prod, w_rnd;
    logic signed [ACC_W-1:0]  w_pterm, w_pterm2;
    logic [ACC_W-1:0]         w_acc_abs;
    logic [ACC_W-1:0]         w_dq;
    logic [KW-1:0]            w_rem;
    logic [KW:0]              w_t;
    logic signed [ACC_W:0]    w_qmag, w_qs, w_sum_ext;
    logic signed [DATA_W-1:0] w_d, w_sum_new;

    // one product per cycle, registered before rounding
    assign w_uop  = uop_at(i_cmd.pc);
    assign w_prod = r_cfg[w_uop.coef] * r_term[w_uop.src];

    // round half up, shift by 28 or by 29 for the half factor
    assign w_rnd    = r_phalf ? ((r_prod + RND_H) >>> 29) : ((r_prod + RND_M) >>> 28);
    assign w_pterm  = r_pdbl ? (w_rnd[ACC_W-1:0] <<< 1) : w_rnd[ACC_W-1:0];
    assign w_pterm2 = r_pneg ? -w_pterm : w_pterm;

    assign w_acc_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // restoring division by k, several bits a cycle
    always_comb begin
        w_rem = r_rem;
        w_dq  = r_dq;
        w_t   = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            w_t  = {w_rem, w_dq[ACC_W-1]};
            w_dq = {w_dq[ACC_W-2:0], 1'b0};
            if (w_t >= {1'b0, i_k}) begin
                w_rem   = KW'(w_t - {1'b0, i_k});
                w_dq[0] = 1'b1;
            end else begin
                w_rem = w_t[KW-1:0];
            end
        end
    end

    assign w_qmag    = {1'b0, r_dq};
    assign w_qs      = r_dsign ? -w_qmag : w_qmag;
    assign w_d       = sat32(w_qs);
    assign w_sum_ext = (ACC_W+1)'(r_sum[i_cmd.elem]) + (ACC_W+1)'(w_d);
    assign w_sum_new = sat32(w_sum_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cfg[i] <= '0;
            end
            for (int i = 0; i < NUM_ELEMS; i++) begin
                r_density[i] <= init_val(i);
            end
            r_step   <= '0;
            r_pvalid <= 1'b0;
            r_acc    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_idx] <= i_cfg_wdata;
            end
            r_pvalid <= i_cmd.issue;
            if (i_cmd.div_start) begin
                r_acc <= '0;
            end else if (r_pvalid) begin
                r_acc <= r_acc + w_pterm2;
            end
            if (i_cmd.load && i_restart) begin
                for (int i = 0; i < NUM_ELEMS; i++) begin
                    r_density[i] <= init_val(i);
                end
                r_step <= '0;
            end else if (i_cmd.commit) begin
                for (int i = 0; i < NUM_ELEMS; i++) begin
                    r_density[i] <= r_sum[i];
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_prod;
        r_phalf <= w_uop.half;
        r_pneg  <= w_uop.neg;
        r_pdbl  <= w_uop.dbl;
        if (i_cmd.load) begin
            for (int i = 0; i < NUM_ELEMS; i++) begin
                r_term[i] <= i_restart ? init_val(i) : r_density[i];
                r_sum[i]  <= i_restart ? init_val(i) : r_density[i];
            end
        end
        if (i_cmd.div_start) begin
            r_dq    <= w_acc_abs;
            r_rem   <= '0;
            r_dsign <= r_acc[ACC_W-1];
        end else if (i_cmd.div_step) begin
            r_dq  <= w_dq;
            r_rem <= w_rem;
        end
        if (i_cmd.write) begin
            r_nterm[i_cmd.elem] <= w_d;
            r_sum[i_cmd.elem]   <= w_sum_new;
        end
        if (i_cmd.copy) begin
            for (int i = 0; i < NUM_ELEMS; i++) begin
                r_term[i] <= r_nterm[i];
            end
        end
        if (i_cmd.commit) begin
            r_out.step_index       <= r_step + 1'b1;
            r_out.pop_upper        <= r_sum[EL_POP_UP];
            r_out.pop_first        <= r_sum[EL_POP_1];
            r_out.pop_second       <= r_sum[EL_POP_2];
            r_out.coh_up_first_re  <= r_sum[EL_C01_RE];
            r_out.coh_up_first_im  <= r_sum[EL_C01_IM];
            r_out.coh_up_second_re <= r_sum[EL_C02_RE];
            r_out.coh_up_second_im <= r_sum[EL_C02_IM];
            r_out.coh_lower_re     <= r_sum[EL_C12_RE];
            r_out.coh_lower_im     <= r_sum[EL_C12_IM];
        end
    end

    assign o_result = r_out;

endmodule

// ===== design/three_level_bloch_taylor_step_top.sv =====
`timescale 1ns / 1ps

// three-level bloch taylor step: holds the nine real density-matrix components
// (three populations, three complex coherences, q2.30) and advances them by one
// time step per item with a taylor series of SERIES_TERMS terms, rates in q4.28
// pre-scaled by the step. each term runs the 45 products of the bloch right-hand
// side through one shared 32x32 multiplier, and each of the nine derivatives
// then passes a divide by k. a finished result sits in an output register, so
// the next item is taken while it waits. restart=1 reloads the initial state
// (lower populations one half) and clears the step count first. configuration
// registers are to be written only while the block is idle; the block itself
// does not enforce this. the divided terms and the running sums saturate at
// 32 bits.
module three_level_bloch_taylor_step_top #(
    parameter int SERIES_TERMS = tlbts_pkg::TLBTS_SERIES_TERMS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tlbts_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlbts_pkg::DATA_W-1:0]    i_cfg_wdata,
    tlbts_in_if.sink                        i_item,
    tlbts_out_if.source                     o_result
);
    import tlbts_pkg::*;

    localparam int KW = $clog2(SERIES_TERMS);

    t_cmd          w_cmd;
    logic [KW-1:0] w_k;
    logic          w_in_ready;
    logic          w_out_valid;
    t_result       w_res;

    // sequencer: product issue, divide and write-back per element, per term
    tlbts_ctrl #(
        .SERIES_TERMS(SERIES_TERMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .o_k         (w_k)
    );

    // state, series storage, multiplier, accumulator and divider
    tlbts_dp #(
        .SERIES_TERMS(SERIES_TERMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_restart   (i_item.restart),
        .i_cmd       (w_cmd),
        .i_k         (w_k),
        .o_result    (w_res)
    );

    assign i_item.ready              = w_in_ready;
    assign o_result.valid            = w_out_valid;
    assign o_result.step_index       = w_res.step_index;
    assign o_result.pop_upper        = w_res.pop_upper;
    assign o_result.pop_first        = w_res.pop_first;
    assign o_result.pop_second       = w_res.pop_second;
    assign o_result.coh_up_first_re  = w_res.coh_up_first_re;
    assign o_result.coh_up_first_im  = w_res.coh_up_first_im;
    assign o_result.coh_up_second_re = w_res.coh_up_second_re;
    assign o_result.coh_up_second_im = w_res.coh_up_second_im;
    assign o_result.coh_lower_re     = w_res.coh_lower_re;
    assign o_result.coh_lower_im     = w_res.coh_lower_im;

    // no new item while a step is in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item accepted while a step is running");

    // products are issued only while stepping
    a_no_issue_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.ready && w_cmd.issue))
        else $error("product issued while idle");

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!o_result.valid || o_result.ready))
        else $error("pending result overwritten");

    // commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_result.valid)
        else $error("committed step not presented");

endmodule

// ===== tb/tlbts_checker.sv =====
`timescale 1ns / 1ps

module tlbts_checker
    import tlbts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    tlbts_in_if                  mon_in,
    tlbts_out_if                 mon_out,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int N_FIELDS = NUM_ELEMS + 1;

    longint      rate_q28 [NUM_CFG];
    longint      density_q30 [NUM_ELEMS];
    logic [31:0] steps_taken;
    t_result     step_results_q[$];
    int          mismatches;

    // rounded q4.28 x q2.30 product, floor after adding one half
    function automatic longint rprod(longint r, longint v, int sh);
        return (r * v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // bloch right-hand side applied to y, divided by k
    task automatic bloch_term(input longint y[NUM_ELEMS], input longint k,
                              output longint d[NUM_ELEMS]);
        longint g, r1, r2, a, b, c, d1, d2;
        longint s[NUM_ELEMS];
        g  = rate_q28[CFG_DECAY];     r1 = rate_q28[CFG_RELAX];
        r2 = rate_q28[CFG_DEPHASE];   a  = rate_q28[CFG_DRIVE1];
        b  = rate_q28[CFG_DRIVE2_RE]; c  = rate_q28[CFG_DRIVE2_IM];
        d1 = rate_q28[CFG_DETUNE1];   d2 = rate_q28[CFG_DETUNE2];
        s[EL_POP_UP] = -rprod(g, y[EL_POP_UP], 28) - 2 * (rprod(a, y[EL_C01_RE], 28)
                     + rprod(b, y[EL_C02_RE], 28) + rprod(c, y[EL_C02_IM], 28));
        s[EL_POP_1]  = rprod(g, y[EL_POP_UP], 29) - rprod(r1, y[EL_POP_1], 29)
                     + rprod(r1, y[EL_POP_2], 29) + 2 * rprod(a, y[EL_C01_RE], 28);
        s[EL_POP_2]  = rprod(g, y[EL_POP_UP], 29) - rprod(r1, y[EL_POP_2], 29)
                     + rprod(r1, y[EL_POP_1], 29)
                     + 2 * (rprod(b, y[EL_C02_RE], 28) + rprod(c, y[EL_C02_IM], 28));
        s[EL_C01_RE] = -rprod(g, y[EL_C01_RE], 29) - rprod(d2, y[EL_C01_IM], 28)
                     + rprod(a, y[EL_POP_UP], 28) - rprod(a, y[EL_POP_1], 28)
                     - rprod(b, y[EL_C12_IM], 28) + rprod(c, y[EL_C12_RE], 28);
        s[EL_C01_IM] = -rprod(g, y[EL_C01_IM], 29) + rprod(d2, y[EL_C01_RE], 28)
                     - rprod(b, y[EL_C12_RE], 28) - rprod(c, y[EL_C12_IM], 28);
        s[EL_C02_RE] = -rprod(g, y[EL_C02_RE], 29) - rprod(d1, y[EL_C02_IM], 28)
                     + rprod(b, y[EL_POP_UP], 28) - rprod(b, y[EL_POP_2], 28)
                     - rprod(a, y[EL_C12_IM], 28);
        s[EL_C02_IM] = -rprod(g, y[EL_C02_IM], 29) + rprod(d1, y[EL_C02_RE], 28)
                     + rprod(c, y[EL_POP_UP], 28) - rprod(c, y[EL_POP_2], 28)
                     + rprod(a, y[EL_C12_RE], 28);
        s[EL_C12_RE] = -rprod(r2, y[EL_C12_RE], 29) - rprod(d2, y[EL_C12_IM], 28)
                     + rprod(d1, y[EL_C12_IM], 28) + rprod(b, y[EL_C01_IM], 28)
                     - rprod(a, y[EL_C02_IM], 28) - rprod(c, y[EL_C01_RE], 28);
        s[EL_C12_IM] = -rprod(r2, y[EL_C12_IM], 29) + rprod(d2, y[EL_C12_RE], 28)
                     - rprod(d1, y[EL_C12_RE], 28) + rprod(b, y[EL_C01_RE], 28)
                     + rprod(a, y[EL_C02_RE], 28) + rprod(c, y[EL_C01_IM], 28);
        for (int i = 0; i < NUM_ELEMS; i++) d[i] = clamp32(s[i] / k);
    endtask

    task automatic load_initial();
        for (int i = 0; i < NUM_ELEMS; i++) density_q30[i] = 0;
        density_q30[EL_POP_1] = HALF_Q30;
        density_q30[EL_POP_2] = HALF_Q30;
        steps_taken = '0;
    endtask

    task automatic taylor_step(input logic restart, output t_result res);
        longint term[NUM_ELEMS];
        longint nxt[NUM_ELEMS];
        longint total[NUM_ELEMS];
        logic [NUM_ELEMS*DATA_W-1:0] packed_state;
        if (restart) load_initial();
        for (int i = 0; i < NUM_ELEMS; i++) begin
            term[i]  = density_q30[i];
            total[i] = density_q30[i];
        end
        for (int k = 1; k < TLBTS_SERIES_TERMS; k++) begin
            bloch_term(term, longint'(k), nxt);
            for (int i = 0; i < NUM_ELEMS; i++) begin
                term[i]  = nxt[i];
                total[i] = clamp32(total[i] + nxt[i]);
            end
        end
        for (int i = 0; i < NUM_ELEMS; i++) begin
            density_q30[i] = total[i];
            packed_state[(NUM_ELEMS-1-i)*DATA_W +: DATA_W] = total[i][31:0];
        end
        steps_taken = steps_taken + 1;
        res = {steps_taken, packed_state};
    endtask

    function automatic string field_name(int i);
        case (i)
            0: return "step_index";
            1: return "pop_upper";
            2: return "pop_first";
            3: return "pop_second";
            4: return "coh_up_first_re";
            5: return "coh_up_first_im";
            6: return "coh_up_second_re";
            7: return "coh_up_second_im";
            8: return "coh_lower_re";
            default: return "coh_lower_im";
        endcase
    endfunction

    initial begin
        for (int i = 0; i < NUM_CFG; i++) rate_q28[i] = 0;
        load_initial();
        mismatches = 0;
    end

    assign o_fail_count = mismatches;

    always @(posedge i_clk) begin
        t_result want, got;
        logic [31:0] w, g;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) rate_q28[i] = 0;
            load_initial();
        end else begin
            if (i_cfg_we) rate_q28[i_cfg_idx] = longint'($signed(i_cfg_wdata));
            if (mon_in.valid && mon_in.ready) begin
                taylor_step(mon_in.restart, want);
                step_results_q.push_back(want);
            end
            if (mon_out.valid && mon_out.ready) begin
                got = {mon_out.step_index, mon_out.pop_upper, mon_out.pop_first,
                       mon_out.pop_second, mon_out.coh_up_first_re,
                       mon_out.coh_up_first_im, mon_out.coh_up_second_re,
                       mon_out.coh_up_second_im, mon_out.coh_lower_re,
                       mon_out.coh_lower_im};
                if (step_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result step %0d", got.step_index);
                end else begin
                    want = step_results_q.pop_front();
                    for (int f = 0; f < N_FIELDS; f++) begin
                        w = want[(N_FIELDS-1-f)*32 +: 32];
                        g = got[(N_FIELDS-1-f)*32 +: 32];
                        if (w !== g) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("mismatch step %0d %s: expected %h actual %h",
                                         want.step_index, field_name(f), w, g);
                        end
                    end
                end
            end
        end
        o_pending = step_results_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tlbts_pkg::*;

    localparam int N_RANDOM    = 600;
    localparam int N_PHASES    = 6;
    localparam int ITEM_CYCLES = (TLBTS_SERIES_TERMS - 1) * 118 + 2;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DATA_W-1:0]    i_cfg_wdata;
    int                   fail_count;
    int                   pending;
    int                   items_sent;
    int                   restarts_sent;
    int                   settings_used;

    tlbts_in_if  item_if ();
    tlbts_out_if result_if ();

    three_level_bloch_taylor_step_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // watches both channels and the register port, predicts and compares
    tlbts_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .mon_in       (item_if),
        .mon_out      (result_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    // receiver: alternates between never stalling, light and heavy stalls
    int ready_mode = 0;
    int ready_left = 0;
    initial result_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(200, 3000);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            0: result_if.ready <= 1'b1;
            1: result_if.ready <= ($urandom_range(0, 3) != 0);
            default: result_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // burst bookkeeping for the sender
    int burst_left = 0;

    // one item on the input channel; held until taken
    task automatic send_item(input logic restart);
        item_if.valid   <= 1'b1;
        item_if.restart <= restart;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        items_sent++;
        if (restart) restarts_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // end of burst: drop valid and idle for a random gap
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    // blocks until every outstanding result is back, then a little slack
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // writes all eight rate registers back to back
    task automatic load_rates(input logic [DATA_W-1:0] r[NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_wdata <= r[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_used++;
    endtask

    // mostly physically small rates, with full-range and extreme values mixed in
    function automatic logic [DATA_W-1:0] pick_rate();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        if (sel < 85) return $urandom();
        case ($urandom_range(0, 2))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return 32'h0;
        endcase
    endfunction

    initial begin
        logic [DATA_W-1:0] rates[NUM_CFG];
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_wdata     <= '0;
        item_if.valid   <= 1'b0;
        item_if.restart <= 1'b0;
        items_sent    = 0;
        restarts_sent = 0;
        settings_used = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset rates: the state must not move, only the step count
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();

        // moderate physical rates, steps with and without restart
        foreach (rates[i]) rates[i] = 32'h0040_0000 + (i << 20);
        load_rates(rates);
        for (int n = 0; n < 8; n++) send_item(n == 4);
        wait_drained();

        // every rate at the positive limit drives the sums into saturation
        foreach (rates[i]) rates[i] = 32'h7FFF_FFFF;
        load_rates(rates);
        for (int n = 0; n < 5; n++) send_item(n == 3);
        wait_drained();

        // every rate at the negative limit
        foreach (rates[i]) rates[i] = 32'h8000_0000;
        load_rates(rates);
        for (int n = 0; n < 5; n++) send_item(n == 0);
        wait_drained();

        // random phases; each begins drained, so the sender also waits for all results
        for (int p = 0; p < N_PHASES; p++) begin
            foreach (rates[i]) rates[i] = pick_rate();
            load_rates(rates);
            for (int n = 0; n < N_RANDOM / N_PHASES; n++)
                send_item($urandom_range(0, 9) == 0);
            wait_drained();
        end

        // final drain plus one item's worth of latency
        repeat (ITEM_CYCLES + 100) @(posedge i_clk);
        $display("%0d items (%0d with restart) over %0d rate settings incl. both limits",
                 items_sent, restarts_sent, settings_used);
        $display("random bursts and gaps on the sender, three stall patterns on the receiver");
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #25_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
